// ===== hdl/lgs_pkg.sv =====
// Shared types and constants for the life generation step block.
package lgs_pkg;

    // Command codes on the input channel
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;

    // Register and field widths
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned COORD_W = 6;

    // Neighbour count, 0 to 8
    typedef logic [3:0] count_t;

    // Rule B3/S23
    localparam count_t BIRTH_COUNT   = 4'd3;
    localparam count_t SURVIVE_COUNT = 4'd2;

endpackage

// ===== hdl/life_generation_step.sv =====
// Top level of the toroidal B3/S23 grid: sequencer, row memory and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries cmd, cell_x, cell_y, cell_value.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Every command gives exactly one result on the output channel
//   (out_valid/out_stall): cell_alive and neighbor_count.
//   Configuration: cfg_we with cfg_index 0 (grid_width) or 1 (grid_height) and
//   cfg_data; the user must write only while the block is idle; it is not enforced.
// Steps from input transfer to result transfer, then back to idle for the next input:
//   write cell          : row read-modify-write, three row reads, count
//   read cell           : three row reads, count
//   clear, out of range : result directly
//   advance             : each row of the effective height takes
//                         one memory read and one pass of the shared row counter
//                         followed by the row write
//   in_stall stays high until the result is taken.
// Reset clears every row at once through per-row valid bits and sets the
// size to 64 by 64. A stalled result is held until out_stall drops.
module life_generation_step #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 cmd,
    input  logic [lgs_pkg::COORD_W-1:0] cell_x,
    input  logic [lgs_pkg::COORD_W-1:0] cell_y,
    input  logic                       cell_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       cell_alive,
    output logic [3:0]                 neighbor_count
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WR_MOD   = 4'd1;
    localparam logic [3:0] ST_RD_UP    = 4'd2;
    localparam logic [3:0] ST_RD_MID   = 4'd3;
    localparam logic [3:0] ST_RD_DN    = 4'd4;
    localparam logic [3:0] ST_RD_LAST  = 4'd5;
    localparam logic [3:0] ST_CNT      = 4'd6;
    localparam logic [3:0] ST_AV_TOP   = 4'd7;
    localparam logic [3:0] ST_AV_ROW0  = 4'd8;
    localparam logic [3:0] ST_AV_CALC  = 4'd9;
    localparam logic [3:0] ST_AV_FETCH = 4'd10;
    localparam logic [3:0] ST_OUT      = 4'd11;

    // Control registers
    logic [3:0]                state_reg, state_next;
    logic [lgs_pkg::CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [MAX_HEIGHT-1:0]     row_valid_reg, row_valid_next;
    logic                      rvalid_reg;

    // Payload registers
    logic [1:0]            cmd_reg, cmd_next;
    logic [XW-1:0]         x_reg, x_next;
    logic [AW-1:0]         y_reg, y_next;
    logic                  v_reg, v_next;
    logic [MAX_WIDTH-1:0]  up_reg, up_next;
    logic [MAX_WIDTH-1:0]  mid_reg, mid_next;
    logic [MAX_WIDTH-1:0]  down_reg, down_next;
    logic [MAX_WIDTH-1:0]  row0_reg, row0_next;
    logic                  alive_reg, alive_next;
    lgs_pkg::count_t       count_reg, count_next;
    logic [MAX_WIDTH-1:0]  rdata_reg;

    // Memory ports
    logic [MAX_WIDTH-1:0]  grid_mem [MAX_HEIGHT];
    logic                  mem_re, mem_we;
    logic [AW-1:0]         mem_raddr, mem_waddr;
    logic [MAX_WIDTH-1:0]  mem_wdata;

    // Derived values
    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [AW-1:0]         y_up, y_down;
    logic                  in_xfer, in_range, last_row;
    logic [MAX_WIDTH-1:0]  rd_row, down_sel, modified_row;
    logic [MAX_WIDTH-1:0]  unit_down, unit_fresh;
    lgs_pkg::count_t       unit_counts [MAX_WIDTH];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= lgs_pkg::CFG_W'(64);
            grid_height_reg <= lgs_pkg::CFG_W'(64);
        end
        else if (cfg_we)
        begin
            if (cfg_index == lgs_pkg::REG_GRID_WIDTH)
                grid_width_reg <= cfg_data;
            else if (cfg_index == lgs_pkg::REG_GRID_HEIGHT)
                grid_height_reg <= cfg_data;
        end
    end

    // Effective size: zero acts as one, clamp to the maximum
    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = WW'(1);
        else if (32'(grid_width_reg) > MAX_WIDTH)
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(grid_width_reg);

        if (grid_height_reg == '0)
            eff_h = HW'(1);
        else if (32'(grid_height_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(grid_height_reg);
    end

    // Wrapped row addresses around y_reg
    always_comb
    begin
        if (y_reg == '0)
            y_up = AW'(32'(eff_h) - 1);
        else
            y_up = y_reg - AW'(1);

        last_row = (32'(y_reg) + 1 == 32'(eff_h));
        y_down   = last_row ? '0 : y_reg + AW'(1);
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign in_range = (32'(cell_x) < 32'(eff_w)) && (32'(cell_y) < 32'(eff_h));

    // Row read from memory, dead where the row was never written since clear
    assign rd_row   = rvalid_reg ? rdata_reg : '0;
    assign down_sel = last_row ? row0_reg : rd_row;

    // Read-modify-write of the addressed cell
    always_comb
    begin
        modified_row        = rd_row;
        modified_row[x_reg] = v_reg;
    end

    // Shared row unit
    assign unit_down = (state_reg == ST_AV_CALC) ? down_sel : down_reg;

    lgs_row_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_unit (
        .up     (up_reg),
        .mid    (mid_reg),
        .down   (unit_down),
        .width  (eff_w),
        .fresh  (unit_fresh),
        .counts (unit_counts)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        v_next         = v_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        down_next      = down_reg;
        row0_next      = row0_reg;
        alive_next     = alive_reg;
        count_next     = count_reg;
        mem_re         = 1'b0;
        mem_raddr      = y_reg;
        mem_we         = 1'b0;
        mem_waddr      = y_reg;
        mem_wdata      = modified_row;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next   = cmd;
                    x_next     = XW'(cell_x);
                    y_next     = AW'(cell_y);
                    v_next     = cell_value;
                    alive_next = 1'b0;
                    count_next = '0;
                    unique case (cmd)
                        lgs_pkg::CMD_WRITE:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(cell_y);
                                state_next = ST_WR_MOD;
                            end
                            else
                                state_next = ST_OUT;
                        end
                        lgs_pkg::CMD_READ:
                            state_next = in_range ? ST_RD_UP : ST_OUT;
                        lgs_pkg::CMD_ADVANCE:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(32'(eff_h) - 1);
                            state_next = ST_AV_TOP;
                        end
                        lgs_pkg::CMD_CLEAR:
                        begin
                            row_valid_next = '0;
                            state_next     = ST_OUT;
                        end
                        default:
                            state_next = ST_OUT;
                    endcase
                end
            end

            ST_WR_MOD:
            begin
                mem_we                = 1'b1;
                row_valid_next[y_reg] = 1'b1;
                state_next            = ST_RD_UP;
            end

            // Three row fetches for the neighbour count
            ST_RD_UP:
            begin
                mem_re     = 1'b1;
                mem_raddr  = y_up;
                state_next = ST_RD_MID;
            end
            ST_RD_MID:
            begin
                up_next    = rd_row;
                mem_re     = 1'b1;
                mem_raddr  = y_reg;
                state_next = ST_RD_DN;
            end
            ST_RD_DN:
            begin
                mid_next   = rd_row;
                mem_re     = 1'b1;
                mem_raddr  = y_down;
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST:
            begin
                down_next  = rd_row;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                alive_next = mid_reg[x_reg];
                count_next = unit_counts[x_reg];
                state_next = ST_OUT;
            end

            // Generation sweep
            ST_AV_TOP:
            begin
                up_next    = rd_row;
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = ST_AV_ROW0;
            end
            ST_AV_ROW0:
            begin
                mid_next   = rd_row;
                row0_next  = rd_row;
                y_next     = '0;
                mem_re     = (32'(eff_h) > 1);
                mem_raddr  = AW'(1);
                state_next = ST_AV_CALC;
            end
            ST_AV_CALC:
            begin
                mem_we                = 1'b1;
                mem_wdata             = unit_fresh;
                row_valid_next[y_reg] = 1'b1;
                up_next               = mid_reg;
                mid_next              = down_sel;
                if (last_row)
                    state_next = ST_OUT;
                else
                begin
                    y_next     = y_reg + AW'(1);
                    state_next = ST_AV_FETCH;
                end
            end
            ST_AV_FETCH:
            begin
                mem_re     = !last_row;
                mem_raddr  = y_down;
                state_next = ST_AV_CALC;
            end

            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            if (mem_re)
                rvalid_reg <= row_valid_reg[mem_raddr];
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        v_reg     <= v_next;
        up_reg    <= up_next;
        mid_reg   <= mid_next;
        down_reg  <= down_next;
        row0_reg  <= row0_next;
        alive_reg <= alive_next;
        count_reg <= count_next;
    end

    // Grid memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= grid_mem[mem_raddr];
    end

    assign out_valid      = (state_reg == ST_OUT);
    assign cell_alive     = alive_reg;
    assign neighbor_count = count_reg;

`ifndef NO_ASSERTIONS
    // Never read and write the memory in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("grid memory read and write in the same cycle");

    // The sweep row counter stays inside the height in use
    a_sweep_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AV_CALC) |-> (32'(y_reg) < 32'(eff_h)))
        else $error("generation sweep row beyond height");

    // An advance transfer starts the sweep
    a_adv_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (cmd == lgs_pkg::CMD_ADVANCE)) |=> (state_reg == ST_AV_TOP))
        else $error("advance did not start the sweep");

    // Only cell reads and writes report a live cell or neighbours
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (cell_alive || (neighbor_count != '0)))
        |-> ((cmd_reg == lgs_pkg::CMD_WRITE) || (cmd_reg == lgs_pkg::CMD_READ)))
        else $error("non-zero result for advance or clear");

    // Neighbour count never exceeds eight
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (neighbor_count <= 4'd8))
        else $error("neighbour count above eight");
`endif

endmodule

// ===== hdl/lgs_row_unit.sv =====
// Row-wide neighbour counter and B3/S23 next-row generator with wrap at the grid width.
module lgs_row_unit #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [MAX_WIDTH-1:0]          up,
    input  logic [MAX_WIDTH-1:0]          mid,
    input  logic [MAX_WIDTH-1:0]          down,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
    output logic [MAX_WIDTH-1:0]          fresh,
    output lgs_pkg::count_t               counts [MAX_WIDTH]
);

    localparam int XW = $clog2(MAX_WIDTH);

    logic [XW-1:0] last_col;
    logic          up_last;
    logic          mid_last;
    logic          down_last;

    // Column at the wrap point, needed by column 0
    assign last_col  = XW'(32'(width) - 1);
    assign up_last   = up[last_col];
    assign mid_last  = mid[last_col];
    assign down_last = down[last_col];

    // One counter per column, all independent
    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
        logic            ul, ml, dl;
        logic            ur, mr, dr;
        logic            at_wrap;
        lgs_pkg::count_t cnt;

        assign at_wrap = (32'(c) + 1 == 32'(width));

        if (c == 0) begin : g_left_wrap
            assign ul = up_last;
            assign ml = mid_last;
            assign dl = down_last;
        end
        else begin : g_left
            assign ul = up[c-1];
            assign ml = mid[c-1];
            assign dl = down[c-1];
        end

        // right neighbour wraps to column 0 at the last column in use
        assign ur = at_wrap ? up[0]   : up[(c+1) % MAX_WIDTH];
        assign mr = at_wrap ? mid[0]  : mid[(c+1) % MAX_WIDTH];
        assign dr = at_wrap ? down[0] : down[(c+1) % MAX_WIDTH];

        assign cnt = lgs_pkg::count_t'(ul) + lgs_pkg::count_t'(up[c])
                   + lgs_pkg::count_t'(ur) + lgs_pkg::count_t'(ml)
                   + lgs_pkg::count_t'(mr) + lgs_pkg::count_t'(dl)
                   + lgs_pkg::count_t'(down[c]) + lgs_pkg::count_t'(dr);

        assign counts[c] = cnt;

        // columns beyond the width in use keep their old value
        assign fresh[c] = (32'(c) < 32'(width))
                        ? ((cnt == lgs_pkg::BIRTH_COUNT)
                           || (mid[c] && (cnt == lgs_pkg::SURVIVE_COUNT)))
                        : mid[c];
    end

endmodule

// ===== test/life_generation_step_tb.sv =====
// Self-checking testbench for the toroidal B3/S23 life grid block.
module life_generation_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX    = 64;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 56;
    localparam int LONG_HOLD   = 600;
    localparam int HOLD_AFTER  = 120;

    typedef logic [GRID_MAX-1:0] grid_t [GRID_MAX];

    typedef struct packed {
        logic [1:0]                  op;
        logic [lgs_pkg::COORD_W-1:0] x;
        logic [lgs_pkg::COORD_W-1:0] y;
        logic                        value;
    } cell_cmd_t;

    typedef struct packed {
        logic            alive;
        lgs_pkg::count_t count;
    } cell_report_t;

    // Shadow copy of the grid plus the queue of reports still owed by the block
    class life_scoreboard;
        grid_t                     cells;
        logic [lgs_pkg::CFG_W-1:0] width_reg;
        logic [lgs_pkg::CFG_W-1:0] height_reg;
        cell_report_t              due_reports[$];
        int unsigned               mismatches;
        int unsigned               reports_taken;

        function new();
            foreach (cells[r])
                cells[r] = '0;
            width_reg     = 7'd64;
            height_reg    = 7'd64;
            mismatches    = 0;
            reports_taken = 0;
        endfunction

        // Size actually in use: zero acts as one, oversize clamps to the maximum
        function int unsigned span(logic [lgs_pkg::CFG_W-1:0] raw);
            if (raw == 0)
                return 1;
            if (raw > GRID_MAX)
                return GRID_MAX;
            return raw;
        endfunction

        function void set_register(logic [1:0] idx, logic [lgs_pkg::CFG_W-1:0] val);
            if (idx == lgs_pkg::REG_GRID_WIDTH)
                width_reg = val;
            else if (idx == lgs_pkg::REG_GRID_HEIGHT)
                height_reg = val;
        endfunction

        // Each of the eight positions wraps on its own, so tiny grids count a cell twice
        function lgs_pkg::count_t live_neighbours(grid_t g, int unsigned x, int unsigned y,
                                                  int unsigned w, int unsigned h);
            int unsigned xl, xr, yu, yd;
            xl = (x + w - 1) % w;
            xr = (x + 1) % w;
            yu = (y + h - 1) % h;
            yd = (y + 1) % h;
            return lgs_pkg::count_t'(g[yu][xl]) + lgs_pkg::count_t'(g[yu][x])
                 + lgs_pkg::count_t'(g[yu][xr]) + lgs_pkg::count_t'(g[y][xl])
                 + lgs_pkg::count_t'(g[y][xr]) + lgs_pkg::count_t'(g[yd][xl])
                 + lgs_pkg::count_t'(g[yd][x]) + lgs_pkg::count_t'(g[yd][xr]);
        endfunction

        // All cells in use update together from the old generation
        function void advance_generation();
            grid_t           prev;
            int unsigned     w, h;
            lgs_pkg::count_t n;
            prev = cells;
            w    = span(width_reg);
            h    = span(height_reg);
            for (int unsigned y = 0; y < h; y++)
            begin
                for (int unsigned x = 0; x < w; x++)
                begin
                    n = live_neighbours(prev, x, y, w, h);
                    cells[y][x] = (n == lgs_pkg::BIRTH_COUNT)
                               || (prev[y][x] && n == lgs_pkg::SURVIVE_COUNT);
                end
            end
        endfunction

        function void note_command(cell_cmd_t c);
            cell_report_t rep;
            int unsigned  w, h;
            w   = span(width_reg);
            h   = span(height_reg);
            rep = '0;
            case (c.op)
                lgs_pkg::CMD_WRITE, lgs_pkg::CMD_READ:
                begin
                    // out-of-range coordinates leave the grid alone and report zero
                    if (c.x < w && c.y < h)
                    begin
                        if (c.op == lgs_pkg::CMD_WRITE)
                            cells[c.y][c.x] = c.value;
                        rep.alive = cells[c.y][c.x];
                        rep.count = live_neighbours(cells, c.x, c.y, w, h);
                    end
                end
                lgs_pkg::CMD_ADVANCE:
                    advance_generation();
                lgs_pkg::CMD_CLEAR:
                begin
                    // clear reaches the whole memory, not just the area in use
                    foreach (cells[r])
                        cells[r] = '0;
                end
            endcase
            due_reports.push_back(rep);
        endfunction

        function void check_report(logic alive, logic [3:0] count);
            cell_report_t want;
            reports_taken++;
            if (due_reports.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            if (alive !== want.alive)
            begin
                $error("cell_alive: expected %0d, got %0d", want.alive, alive);
                mismatches++;
            end
            if (count !== want.count)
            begin
                $error("neighbor_count: expected %0d, got %0d", want.count, count);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction

        function int unsigned closing_errors();
            if (due_reports.size() != 0)
            begin
                $error("%0d cell reports never arrived", due_reports.size());
                mismatches += due_reports.size();
            end
            return mismatches;
        endfunction
    endclass

    // Hand-picked opening: wrap across corners, a blinker, a kill, clear
    localparam cell_cmd_t DIRECTED [22] = '{
        '{lgs_pkg::CMD_READ,    6'd0,  6'd0,  1'b0},
        '{lgs_pkg::CMD_WRITE,   6'd63, 6'd63, 1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd0,  6'd0,  1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd63, 6'd0,  1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd0,  6'd63, 1'b1},
        '{lgs_pkg::CMD_READ,    6'd0,  6'd0,  1'b0},
        '{lgs_pkg::CMD_READ,    6'd63, 6'd63, 1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd10, 6'd10, 1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd11, 6'd10, 1'b1},
        '{lgs_pkg::CMD_WRITE,   6'd12, 6'd10, 1'b1},
        '{lgs_pkg::CMD_READ,    6'd11, 6'd10, 1'b0},
        '{lgs_pkg::CMD_ADVANCE, 6'd5,  6'd7,  1'b1},
        '{lgs_pkg::CMD_READ,    6'd11, 6'd9,  1'b0},
        '{lgs_pkg::CMD_READ,    6'd11, 6'd11, 1'b0},
        '{lgs_pkg::CMD_READ,    6'd10, 6'd10, 1'b0},
        '{lgs_pkg::CMD_READ,    6'd0,  6'd63, 1'b0},
        '{lgs_pkg::CMD_WRITE,   6'd11, 6'd10, 1'b0},
        '{lgs_pkg::CMD_ADVANCE, 6'd63, 6'd63, 1'b0},
        '{lgs_pkg::CMD_READ,    6'd11, 6'd10, 1'b0},
        '{lgs_pkg::CMD_CLEAR,   6'd42, 6'd21, 1'b1},
        '{lgs_pkg::CMD_READ,    6'd63, 6'd63, 1'b0},
        '{lgs_pkg::CMD_READ,    6'd0,  6'd0,  1'b0}
    };

    // Grid sizes per phase, including zero and oversize register values
    localparam logic [lgs_pkg::CFG_W-1:0] PHASE_W [14] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd1, 7'd6, 7'd127,
        7'd4, 7'd8, 7'd64, 7'd65, 7'd16, 7'd7, 7'd64
    };
    localparam logic [lgs_pkg::CFG_W-1:0] PHASE_H [14] = '{
        7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd2, 7'd127,
        7'd9, 7'd8, 7'd64, 7'd3, 7'd12, 7'd100, 7'd64
    };

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [lgs_pkg::CFG_W-1:0]   cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  cmd;
    logic [lgs_pkg::COORD_W-1:0] cell_x;
    logic [lgs_pkg::COORD_W-1:0] cell_y;
    logic                        cell_value;
    logic                        out_valid;
    logic                        out_stall;
    logic                        cell_alive;
    logic [3:0]                  neighbor_count;

    life_scoreboard tracker = new();

    life_generation_step i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .cell_value     (cell_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_alive     (cell_alive),
        .neighbor_count (neighbor_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Writes, reads, advances and rare clears; some coordinates land outside the grid
    function automatic cell_cmd_t random_command(int unsigned w, int unsigned h);
        cell_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = lgs_pkg::CMD_WRITE;
        else if (pick < 75)
            c.op = lgs_pkg::CMD_READ;
        else if (pick < 97)
            c.op = lgs_pkg::CMD_ADVANCE;
        else
            c.op = lgs_pkg::CMD_CLEAR;
        if ($urandom_range(0, 4) == 0)
        begin
            c.x = lgs_pkg::COORD_W'($urandom_range(0, GRID_MAX - 1));
            c.y = lgs_pkg::COORD_W'($urandom_range(0, GRID_MAX - 1));
        end
        else
        begin
            c.x = lgs_pkg::COORD_W'($urandom_range(0, w - 1));
            c.y = lgs_pkg::COORD_W'($urandom_range(0, h - 1));
        end
        c.value = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // One input transfer; valid stays high afterwards unless the next call idles first
    task automatic send_command(input cell_cmd_t c, input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd        <= c.op;
        cell_x     <= c.x;
        cell_y     <= c.y;
        cell_value <= c.value;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_command(c);
    endtask

    // Stop offering, wait for every owed report, then let the block settle
    task automatic drain_block(input int unsigned settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_grid_size(input logic [lgs_pkg::CFG_W-1:0] w,
                                 input logic [lgs_pkg::CFG_W-1:0] h);
        drain_block(4);
        cfg_we    <= 1'b1;
        cfg_index <= lgs_pkg::REG_GRID_WIDTH;
        cfg_data  <= w;
        tracker.set_register(lgs_pkg::REG_GRID_WIDTH, w);
        @(negedge clk);
        cfg_index <= lgs_pkg::REG_GRID_HEIGHT;
        cfg_data  <= h;
        tracker.set_register(lgs_pkg::REG_GRID_HEIGHT, h);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus: reset, directed opening, then random phases at each grid size
    initial
    begin : stimulus
        cell_cmd_t c;
        bit        calm;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = lgs_pkg::REG_GRID_WIDTH;
        cfg_data   = '0;
        in_valid   = 1'b0;
        cmd        = lgs_pkg::CMD_READ;
        cell_x     = '0;
        cell_y     = '0;
        cell_value = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_command(DIRECTED[i], i % 3);

        foreach (PHASE_W[p])
        begin
            set_grid_size(PHASE_W[p], PHASE_H[p]);
            // now and then a phase with back-to-back transfers
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
            begin
                c = random_command(tracker.span(tracker.width_reg),
                                   tracker.span(tracker.height_reg));
                send_command(c, calm ? 0 : pick_gap());
            end
        end

        drain_block(16);
        if (tracker.closing_errors() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: free stretches, random stalls, and one long hold-off to back up the input
    initial
    begin : receiver
        int unsigned stall_left;
        int unsigned free_left;
        bit          held;
        out_stall  = 1'b0;
        stall_left = 0;
        free_left  = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && tracker.reports_taken >= HOLD_AFTER)
            begin
                held       = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
                else
                begin
                    stall_left = pick_gap();
                    free_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                             : $urandom_range(0, 10);
                end
            end
        end
    end

    // Result transfers are checked against the oldest owed report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_report(cell_alive, neighbor_count);
    end

    // Watchdog on cycles with no transfer on either channel
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
